// ===== design/trl_pkg.sv =====
// trl_pkg: shared sizes, codes and structs of the tile residency table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package trl_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int STAMP_WIDTH = 32;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = 7;

   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [STAMP_WIDTH-1:0] stamp_type;
   typedef logic [SLOT_W-1:0]      slot_type;
   typedef logic [COUNT_W-1:0]     count_type;

   localparam logic [2:0] OP_TOUCH     = 3'd0;
   localparam logic [2:0] OP_CREATE    = 3'd1;
   localparam logic [2:0] OP_DROP      = 3'd2;
   localparam logic [2:0] OP_CLR_SAVE  = 3'd3;
   localparam logic [2:0] OP_CLR_PUB   = 3'd4;
   localparam logic [2:0] OP_LIST      = 3'd5;
   localparam logic [2:0] OP_QUERY     = 3'd6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NONE      = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_SAT       = 2'd3;

   // write command broadcast along the row of cells
   typedef struct packed {
      logic      create;
      logic      stamp_en;
      logic      mark;
      logic      drop;
      logic      clr_save;
      logic      clr_pub;
      key_type   key;
      stamp_type stamp;
   } cell_cmd_type;

   // what one cell shows to the controller
   typedef struct packed {
      logic      valid;
      logic      match;
      logic      save_dirty;
      logic      publish_dirty;
      key_type   key;
      stamp_type stamp;
   } cell_view_type;
endpackage
`default_nettype wire

// ===== design/tile_residency_lru_table.sv =====
// tile_residency_lru_table: recency table of resident tiles with dirty marks
// depends on trl_pkg and trl_cell
// touch, create, drop, query, clears: S_LOOK, then S_EXEC; result registered
// cold listing: each listed tile costs one pass over the row,
//   scanned one entry per cycle; busy stays high until last
// a new request is taken only in S_IDLE, once the previous one has finished
// reset: synchronous, clears every entry's valid and marks, counter, occupancy
`timescale 1ns / 1ps
`default_nettype none
module tile_residency_lru_table (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [2:0]           req_operation,
   input  wire trl_pkg::key_type     req_tile_key,
   input  wire logic                 req_changed,
   input  wire logic                 csr_write_en,
   input  wire trl_pkg::count_type   csr_write_data,
   output logic                      rsp_valid,
   output trl_pkg::key_type          rsp_result_key,
   output trl_pkg::stamp_type        rsp_touch_stamp,
   output logic                      rsp_save_dirty,
   output logic                      rsp_publish_dirty,
   output trl_pkg::count_type        rsp_resident_count,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last
);
   import trl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_EXEC = 4'b0100,
      S_SCAN = 4'b1000
   } state_type;

   localparam stamp_type STAMP_MAX = '1;

   state_type state_ff, state_in;
   logic [2:0] op_ff;
   key_type    key_ff;
   logic       chg_ff;
   count_type  max_ff, occ_ff, occ_in;
   stamp_type  ctr_ff, ctr_in;

   // registered lookup results
   logic [TABLE_DEPTH-1:0] hit_vec_ff, free_vec_ff;

   // listing walk
   slot_type   idx_ff, idx_in;
   count_type  left_ff, left_in;
   logic       first_ff, first_in;
   stamp_type  prev_stamp_ff, prev_stamp_in;
   slot_type   prev_slot_ff, prev_slot_in;
   logic       best_ok_ff, best_ok_in;
   stamp_type  best_stamp_ff, best_stamp_in;
   slot_type   best_slot_ff, best_slot_in;
   key_type    best_key_ff, best_key_in;
   logic       best_sd_ff, best_sd_in, best_pd_ff, best_pd_in;

   // response registers
   logic       rv_ff, rv_in;
   key_type    rk_ff, rk_in;
   stamp_type  rs_ff, rs_in;
   logic       rsd_ff, rsd_in, rpd_ff, rpd_in, rl_ff, rl_in;
   count_type  rc_ff, rc_in;
   logic [1:0] rst_ff, rst_in;

   cell_cmd_type  cmd;
   logic [TABLE_DEPTH-1:0] sel;
   cell_view_type view [TABLE_DEPTH];

   // row of entries, each comparing its key against the request
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      trl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .sel      (sel[g]),
         .look_key (key_ff),
         .view     (view[g])
      );
   end

   // one-hot hit and lowest free slot, turned into slot numbers
   logic [TABLE_DEPTH-1:0] free_low;
   slot_type hit_slot, free_slot;
   logic     hit, any_free;
   always_comb begin
      free_low = free_vec_ff & (~free_vec_ff + 1'b1);
      hit_slot  = '0;
      free_slot = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hit_vec_ff[i]) hit_slot  = hit_slot  | slot_type'(i);
         if (free_low[i])   free_slot = free_slot | slot_type'(i);
      end
      hit      = |hit_vec_ff;
      any_free = |free_vec_ff;
   end

   cell_view_type hv, sv;
   assign hv = view[hit_slot];
   assign sv = view[idx_ff];

   // stamp counter saturates at its top value
   logic      sat;
   stamp_type next_stamp;
   assign sat        = (ctr_ff == STAMP_MAX);
   assign next_stamp = sat ? ctr_ff : ctr_ff + 1'b1;

   // listing candidate test for the entry under the scan pointer
   logic elig, better;
   assign elig   = sv.valid && (first_ff || sv.stamp > prev_stamp_ff ||
                   (sv.stamp == prev_stamp_ff && idx_ff > prev_slot_ff));
   assign better = elig && (!best_ok_ff || sv.stamp < best_stamp_ff);

   // best candidate so far, carried with its key and marks
   stamp_type pick_stamp;
   slot_type  pick_slot;
   key_type   pick_key;
   logic      pick_sd, pick_pd;
   assign pick_stamp = better ? sv.stamp         : best_stamp_ff;
   assign pick_slot  = better ? idx_ff           : best_slot_ff;
   assign pick_key   = better ? sv.key           : best_key_ff;
   assign pick_sd    = better ? sv.save_dirty    : best_sd_ff;
   assign pick_pd    = better ? sv.publish_dirty : best_pd_ff;

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      ctr_in        = ctr_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      first_in      = first_ff;
      prev_stamp_in = prev_stamp_ff;
      prev_slot_in  = prev_slot_ff;
      best_ok_in    = best_ok_ff;
      best_stamp_in = best_stamp_ff;
      best_slot_in  = best_slot_ff;
      best_key_in   = best_key_ff;
      best_sd_in    = best_sd_ff;
      best_pd_in    = best_pd_ff;
      rv_in  = 1'b0;
      rk_in  = rk_ff;
      rs_in  = rs_ff;
      rsd_in = rsd_ff;
      rpd_in = rpd_ff;
      rc_in  = rc_ff;
      rst_in = rst_ff;
      rl_in  = rl_ff;
      cmd    = '0;
      cmd.key   = key_ff;
      cmd.stamp = next_stamp;
      sel    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_LOOK;
         end
         S_LOOK: state_in = S_EXEC;
         S_EXEC: begin
            rv_in  = 1'b1;
            rl_in  = 1'b1;
            rk_in  = key_ff;
            rs_in  = '0;
            rsd_in = 1'b0;
            rpd_in = 1'b0;
            rst_in = ST_OK;
            state_in = S_IDLE;
            unique case (op_ff)
               OP_TOUCH, OP_CREATE: begin
                  if (hit) begin
                     sel[hit_slot] = 1'b1;
                     if (op_ff == OP_TOUCH) begin
                        cmd.stamp_en = 1'b1;
                        cmd.mark     = chg_ff;
                        ctr_in = next_stamp;
                        rs_in  = next_stamp;
                        rsd_in = hv.save_dirty | chg_ff;
                        rpd_in = hv.publish_dirty | chg_ff;
                        rst_in = sat ? ST_SAT : ST_OK;
                     end else begin
                        rs_in  = hv.stamp;
                        rsd_in = hv.save_dirty;
                        rpd_in = hv.publish_dirty;
                     end
                  end else if (any_free) begin
                     sel[free_slot] = 1'b1;
                     cmd.create   = 1'b1;
                     cmd.stamp_en = 1'b1;
                     cmd.mark     = (op_ff == OP_TOUCH) && chg_ff;
                     occ_in = occ_ff + 1'b1;
                     ctr_in = next_stamp;
                     rs_in  = next_stamp;
                     rsd_in = cmd.mark;
                     rpd_in = cmd.mark;
                     rst_in = sat ? ST_SAT : ST_OK;
                  end else begin
                     rst_in = ST_FULL;
                  end
               end
               OP_DROP: begin
                  if (hit) begin
                     sel[hit_slot] = 1'b1;
                     cmd.drop = 1'b1;
                     occ_in = occ_ff - 1'b1;
                  end else begin
                     rst_in = ST_NONE;
                  end
               end
               OP_CLR_SAVE: begin
                  cmd.clr_save = 1'b1;
                  rk_in = '0;
               end
               OP_CLR_PUB: begin
                  cmd.clr_pub = 1'b1;
                  rk_in = '0;
               end
               OP_LIST: begin
                  rk_in = '0;
                  if (occ_ff <= max_ff) begin
                     rst_in = ST_NONE;
                  end else begin
                     // walk the row once per listed tile
                     rv_in      = 1'b0;
                     left_in    = occ_ff - max_ff;
                     idx_in     = '0;
                     first_in   = 1'b1;
                     best_ok_in = 1'b0;
                     state_in   = S_SCAN;
                  end
               end
               OP_QUERY: begin
                  if (hit) begin
                     rs_in  = hv.stamp;
                     rsd_in = hv.save_dirty;
                     rpd_in = hv.publish_dirty;
                  end else begin
                     rst_in = ST_NONE;
                  end
               end
               default: begin
                  rk_in  = '0;
                  rst_in = ST_NONE;
               end
            endcase
            rc_in = occ_in;
         end
         S_SCAN: begin
            best_ok_in    = best_ok_ff | better;
            best_stamp_in = pick_stamp;
            best_slot_in  = pick_slot;
            best_key_in   = pick_key;
            best_sd_in    = pick_sd;
            best_pd_in    = pick_pd;
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == slot_type'(TABLE_DEPTH - 1)) begin
               // end of a pass: the coldest remaining tile is reported
               rv_in  = 1'b1;
               rk_in  = pick_key;
               rs_in  = pick_stamp;
               rsd_in = pick_sd;
               rpd_in = pick_pd;
               rc_in  = occ_ff;
               rst_in = ST_OK;
               rl_in  = (left_ff == count_type'(1));
               left_in       = left_ff - 1'b1;
               first_in      = 1'b0;
               prev_stamp_in = pick_stamp;
               prev_slot_in  = pick_slot;
               best_ok_in    = 1'b0;
               idx_in        = '0;
               if (left_ff == count_type'(1)) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         ctr_ff   <= '0;
         max_ff   <= count_type'(TABLE_DEPTH);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         ctr_ff   <= ctr_in;
         rv_ff    <= rv_in;
         if (csr_write_en) max_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff  <= req_operation;
         key_ff <= req_tile_key;
         chg_ff <= req_changed;
      end
      if (state_ff == S_LOOK) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_vec_ff[i]  <= view[i].match;
            free_vec_ff[i] <= !view[i].valid;
         end
      end
      idx_ff        <= idx_in;
      left_ff       <= left_in;
      first_ff      <= first_in;
      prev_stamp_ff <= prev_stamp_in;
      prev_slot_ff  <= prev_slot_in;
      best_ok_ff    <= best_ok_in;
      best_stamp_ff <= best_stamp_in;
      best_slot_ff  <= best_slot_in;
      best_key_ff   <= best_key_in;
      best_sd_ff    <= best_sd_in;
      best_pd_ff    <= best_pd_in;
      rk_ff  <= rk_in;
      rs_ff  <= rs_in;
      rsd_ff <= rsd_in;
      rpd_ff <= rpd_in;
      rc_ff  <= rc_in;
      rst_ff <= rst_in;
      rl_ff  <= rl_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_result_key     = rk_ff;
   assign rsp_touch_stamp    = rs_ff;
   assign rsp_save_dirty     = rsd_ff;
   assign rsp_publish_dirty  = rpd_ff;
   assign rsp_resident_count = rc_ff;
   assign rsp_status         = rst_ff;
   assign rsp_last           = rl_ff;
endmodule
`default_nettype wire

// ===== design/trl_cell.sv =====
// trl_cell: one table entry with its own key compare
// depends on trl_pkg
`timescale 1ns / 1ps
`default_nettype none
module trl_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trl_pkg::cell_cmd_type cmd,
   input  wire logic                  sel,
   input  wire trl_pkg::key_type      look_key,
   output trl_pkg::cell_view_type     view
);
   import trl_pkg::*;

   logic      valid_ff, sd_ff, pd_ff;
   key_type   key_ff;
   stamp_type stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sd_ff    <= 1'b0;
         pd_ff    <= 1'b0;
      end else begin
         if (sel && cmd.create) begin
            valid_ff <= 1'b1;
            sd_ff    <= cmd.mark;
            pd_ff    <= cmd.mark;
         end else if (sel && cmd.drop) begin
            valid_ff <= 1'b0;
            sd_ff    <= 1'b0;
            pd_ff    <= 1'b0;
         end else if (sel && cmd.mark) begin
            sd_ff <= 1'b1;
            pd_ff <= 1'b1;
         end else begin
            if (cmd.clr_save) sd_ff <= 1'b0;
            if (cmd.clr_pub)  pd_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sel && cmd.create) key_ff <= cmd.key;
      if (sel && cmd.stamp_en) stamp_ff <= cmd.stamp;
   end

   always_comb begin
      view.valid         = valid_ff;
      view.match         = valid_ff && (key_ff == look_key);
      view.save_dirty    = sd_ff;
      view.publish_dirty = pd_ff;
      view.key           = key_ff;
      view.stamp         = stamp_ff;
   end
endmodule
`default_nettype wire

// ===== design/trl_checker.sv =====
// trl_checker: port-level checks of the tile residency table
// depends on trl_pkg; bound to tile_residency_lru_table
`timescale 1ns / 1ps
`default_nettype none
module trl_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire trl_pkg::stamp_type rsp_touch_stamp,
   input wire trl_pkg::count_type rsp_resident_count,
   input wire logic [1:0]         rsp_status,
   input wire logic               rsp_last
);
   import trl_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request not followed by busy");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_resident_count <= count_type'(TABLE_DEPTH))
      else $error("resident count out of range");
   a_full_stamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_touch_stamp == '0)
      else $error("full table reported a stamp");
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("response right after last");
endmodule

bind tile_residency_lru_table trl_checker u_trl_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_touch_stamp    (rsp_touch_stamp),
   .rsp_resident_count (rsp_resident_count),
   .rsp_status         (rsp_status),
   .rsp_last           (rsp_last)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for tile_residency_lru_table
// depends on trl_pkg and the design files; holds its own table predictor
`timescale 1ns / 1ps
module tb_top;
   import trl_pkg::*;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int KEY_POOL = 72;

   // one result as it appears on the rsp_ ports
   typedef struct packed {
      key_type   key;
      stamp_type stamp;
      logic      save_dirty;
      logic      publish_dirty;
      count_type count;
      logic [1:0] status;
      logic      last;
   } tile_result_type;

   // shadow copy of the table and the queue of results it predicts
   class tile_scoreboard_type;
      bit        valid [TABLE_DEPTH];
      key_type   keys [TABLE_DEPTH];
      stamp_type stamps [TABLE_DEPTH];
      bit        save_m [TABLE_DEPTH];
      bit        pub_m [TABLE_DEPTH];
      stamp_type counter;
      int        occupancy;
      int        resident_limit;
      tile_result_type pending_results[$];

      function new();
         foreach (valid[i]) begin
            valid[i] = 0; save_m[i] = 0; pub_m[i] = 0;
         end
         counter = '0;
         occupancy = 0;
         resident_limit = 64;
      endfunction

      function void push(key_type k, stamp_type s, bit sd, bit pd,
                         logic [1:0] st, bit lst);
         tile_result_type r;
         r.key = k; r.stamp = s; r.save_dirty = sd; r.publish_dirty = pd;
         r.count = count_type'(occupancy); r.status = st; r.last = lst;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function int find_key(key_type k);
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (valid[i] && keys[i] == k) return i;
         return -1;
      endfunction

      function logic [1:0] restamp(int s);
         logic [1:0] st;
         st = ST_OK;
         if (counter != '1) counter = counter + 1;
         else st = ST_SAT;
         stamps[s] = counter;
         return st;
      endfunction

      // predict the results of one accepted request
      function void note_request(logic [2:0] op, key_type k, bit changed);
         int s;
         int n;
         int best;
         int prev_slot;
         stamp_type prev_stamp;
         logic [1:0] st;
         case (op)
            OP_TOUCH, OP_CREATE: begin
               s = find_key(k);
               st = ST_OK;
               if (s < 0) begin
                  for (int i = 0; i < TABLE_DEPTH && s < 0; i++)
                     if (!valid[i]) s = i;
                  if (s < 0) begin
                     push(k, '0, 0, 0, ST_FULL, 1);
                     return;
                  end
                  valid[s] = 1; keys[s] = k; save_m[s] = 0; pub_m[s] = 0;
                  occupancy++;
                  st = restamp(s);
               end else if (op == OP_TOUCH) begin
                  st = restamp(s);
               end
               if (op == OP_TOUCH && changed) begin
                  save_m[s] = 1; pub_m[s] = 1;
               end
               push(k, stamps[s], save_m[s], pub_m[s], st, 1);
            end
            OP_DROP: begin
               s = find_key(k);
               if (s >= 0) begin
                  valid[s] = 0; save_m[s] = 0; pub_m[s] = 0;
                  occupancy--;
               end
               push(k, '0, 0, 0, (s >= 0) ? ST_OK : ST_NONE, 1);
            end
            OP_CLR_SAVE, OP_CLR_PUB: begin
               foreach (valid[i])
                  if (op == OP_CLR_SAVE) save_m[i] = 0; else pub_m[i] = 0;
               push('0, '0, 0, 0, ST_OK, 1);
            end
            OP_LIST: begin
               if (occupancy <= resident_limit) begin
                  push('0, '0, 0, 0, ST_NONE, 1);
                  return;
               end
               n = occupancy - resident_limit;
               if (n > TABLE_DEPTH) n = TABLE_DEPTH;
               prev_slot = -1;
               prev_stamp = '0;
               // walk upward in (stamp, slot) order
               for (int j = 0; j < n; j++) begin
                  best = -1;
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (!valid[i]) continue;
                     if (prev_slot >= 0 && (stamps[i] < prev_stamp ||
                         (stamps[i] == prev_stamp && i <= prev_slot))) continue;
                     if (best < 0 || stamps[i] < stamps[best]) best = i;
                  end
                  push(keys[best], stamps[best], save_m[best], pub_m[best],
                       ST_OK, j == n - 1);
                  prev_stamp = stamps[best];
                  prev_slot = best;
               end
            end
            OP_QUERY: begin
               s = find_key(k);
               if (s < 0) push(k, '0, 0, 0, ST_NONE, 1);
               else push(k, stamps[s], save_m[s], pub_m[s], ST_OK, 1);
            end
            default: push('0, '0, 0, 0, ST_NONE, 1);
         endcase
      endfunction

      // 0 match, 1 nothing expected, 2 field mismatch
      function int check_result(tile_result_type got, output string msg);
         tile_result_type e;
         msg = "";
         if (pending_results.size() == 0) begin
            msg = $sformatf("unexpected result key %h", got.key);
            return 1;
         end
         e = pending_results.pop_front();
         if (got.key !== e.key)
            msg = {msg, $sformatf(" key %h/%h", got.key, e.key)};
         if (got.stamp !== e.stamp)
            msg = {msg, $sformatf(" stamp %0d/%0d", got.stamp, e.stamp)};
         if (got.save_dirty !== e.save_dirty)
            msg = {msg, $sformatf(" save %b/%b", got.save_dirty, e.save_dirty)};
         if (got.publish_dirty !== e.publish_dirty)
            msg = {msg, $sformatf(" pub %b/%b", got.publish_dirty, e.publish_dirty)};
         if (got.count !== e.count)
            msg = {msg, $sformatf(" count %0d/%0d", got.count, e.count)};
         if (got.status !== e.status)
            msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
         if (got.last !== e.last)
            msg = {msg, $sformatf(" last %b/%b", got.last, e.last)};
         return (msg == "") ? 0 : 2;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_operation = '0;
   key_type req_tile_key = '0;
   logic req_changed = 0;
   logic csr_write_en = 0;
   count_type csr_write_data = '0;
   logic rsp_valid;
   key_type rsp_result_key;
   stamp_type rsp_touch_stamp;
   logic rsp_save_dirty, rsp_publish_dirty, rsp_last;
   count_type rsp_resident_count;
   logic [1:0] rsp_status;

   tile_scoreboard_type sb = new();
   int fail_count = 0;
   int cycle_count = 0;
   key_type key_pool [KEY_POOL];

   always #5 clock = ~clock;

   tile_residency_lru_table u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_tile_key(req_tile_key),
      .req_changed(req_changed),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_result_key(rsp_result_key),
      .rsp_touch_stamp(rsp_touch_stamp), .rsp_save_dirty(rsp_save_dirty),
      .rsp_publish_dirty(rsp_publish_dirty),
      .rsp_resident_count(rsp_resident_count),
      .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   task automatic report(string msg);
      $display("mismatch at cycle %0d:%s", cycle_count, msg);
      fail_count++;
   endtask

   // result monitor: every strobed cycle is one result
   always @(posedge clock) begin
      tile_result_type got;
      string msg;
      if (!reset && rsp_valid) begin
         got = '{rsp_result_key, rsp_touch_stamp, rsp_save_dirty,
                 rsp_publish_dirty, rsp_resident_count, rsp_status, rsp_last};
         if (sb.check_result(got, msg) != 0) report(msg);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // one request with a random gap ahead of it; start stays high on a zero gap
   task automatic send(logic [2:0] op, key_type k, bit ch);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_operation <= op;
      req_tile_key <= k;
      req_changed <= ch;
      do @(posedge clock); while (busy);
      sb.note_request(op, k, ch);
   endtask

   // register write only once the table has gone quiet
   task automatic write_limit(int value);
      start <= 0;
      @(posedge clock);
      while (sb.pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en <= 1;
      csr_write_data <= count_type'(value);
      @(posedge clock);
      csr_write_en <= 0;
      sb.resident_limit = value;
   endtask

   function automatic logic [2:0] pick_op(bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (r < (filling ? 60 : 35)) return OP_TOUCH;
      if (r < (filling ? 70 : 50)) return OP_CREATE;
      if (r < (filling ? 74 : 66)) return OP_DROP;
      if (r < 80) return OP_QUERY;
      if (r < 88) return OP_LIST;
      if (r < 93) return OP_CLR_SAVE;
      if (r < 98) return OP_CLR_PUB;
      return OP_UNUSED;
   endfunction

   task automatic random_phase(int items, bit filling);
      key_type k;
      for (int n = 0; n < items; n++) begin
         // mostly pool keys so hits, drops and a full table all occur
         if ($urandom_range(0, 9) == 0) k = $urandom;
         else k = key_pool[$urandom_range(0, KEY_POOL - 1)];
         send(pick_op(filling), k, $urandom_range(0, 1));
      end
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: absent-tile answers, empty listing, unused code
      send(OP_QUERY, 32'h1234_5678, 0);
      send(OP_DROP, '1, 0);
      send(OP_LIST, '0, 0);
      send(OP_UNUSED, 32'hdead_beef, 1);
      // first stamp, extreme keys, marks
      send(OP_TOUCH, '0, 1);
      send(OP_TOUCH, '1, 0);
      send(OP_CREATE, '1, 1);
      send(OP_CREATE, 32'h8000_0001, 1);
      send(OP_TOUCH, '0, 0);
      send(OP_QUERY, '0, 0);
      send(OP_CLR_SAVE, 32'h5555_aaaa, 1);
      send(OP_QUERY, '0, 1);
      send(OP_TOUCH, '1, 1);
      send(OP_CLR_PUB, '0, 0);
      send(OP_QUERY, '1, 0);
      send(OP_DROP, '0, 0);
      send(OP_QUERY, '0, 0);
      send(OP_TOUCH, 32'h7fff_fffe, 1);

      // cold listing with no tiles allowed, then a tie-free walk
      write_limit(0);
      send(OP_LIST, '0, 0);
      write_limit(1);
      send(OP_LIST, '0, 0);

      // fill beyond the table size to hit the full answer
      write_limit(64);
      for (int i = 0; i < 8; i++) send(OP_TOUCH, key_pool[i], 1);
      random_phase(30, 1);
      for (int i = 0; i < KEY_POOL; i++) send(OP_TOUCH, key_pool[i], i[0]);
      send(OP_LIST, '0, 0);

      write_limit(0);
      send(OP_LIST, '0, 0);
      random_phase(25, 0);

      write_limit($urandom_range(1, 63));
      random_phase(25, 1);

      write_limit(64);
      random_phase(20, 0);

      start <= 0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (sb.pending_results.size() != 0) report(" results still expected");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/trl_pkg.sv
design/trl_cell.sv
design/tile_residency_lru_table.sv
design/trl_checker.sv
verif/tb_top.sv
